/* rtl/core/drv_pkg.sv */
`default_nettype none

package drv_pkg;

    // field widths
    localparam int BYTE_W    = 8;
    localparam int XID_W     = 32;
    localparam int VERDICT_W = 3;
    localparam int OPTB_W    = 9;

    // default size of the option area that is kept
    localparam int MAX_OPTION_BYTES_DEF = 312;

    // header layout
    localparam int HDR_LEN   = 236;
    localparam int OPT_START = 240;
    localparam int OP_POS    = 0;
    localparam int XID_FIRST = 4;
    localparam int XID_LAST  = 7;

    localparam logic [BYTE_W-1:0] OP_REPLY  = 8'd2;
    localparam logic [BYTE_W-1:0] OPT_PAD   = 8'd0;
    localparam logic [BYTE_W-1:0] OPT_END   = 8'd255;

    localparam logic [BYTE_W-1:0] COOKIE [4] = '{8'h63, 8'h82, 8'h53, 8'h63};

    // verdict codes
    localparam logic [VERDICT_W-1:0] VERDICT_ACCEPT    = 3'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_NOT_REPLY = 3'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_XID_BAD   = 3'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_COOKIE    = 3'd3;
    localparam logic [VERDICT_W-1:0] VERDICT_NO_END    = 3'd4;

    // byte idx of the xid, idx 0 is the most significant byte
    function automatic logic [BYTE_W-1:0] xid_byte(logic [XID_W-1:0] xid, logic [1:0] idx);
        logic [XID_W-1:0] sh;
        sh = xid >> {~idx, 3'b000};
        return sh[BYTE_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/drv_byte_if.sv */
`default_nettype none

interface drv_byte_if import drv_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] payload_byte;
    logic              is_last;

    modport source (output valid, output payload_byte, output is_last, input ready);
    modport sink   (input valid, input payload_byte, input is_last, output ready);
endinterface

`default_nettype wire

/* rtl/core/drv_result_if.sv */
`default_nettype none

interface drv_result_if import drv_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [VERDICT_W-1:0] verdict;
    logic [OPTB_W-1:0]    option_bytes;

    modport source (output valid, output verdict, output option_bytes, input ready);
    modport sink   (input valid, input verdict, input option_bytes, output ready);
endinterface

`default_nettype wire

/* rtl/core/dhcp_reply_validator.sv */
// the verdict is registered with the last byte, in the skid entry if a result still waits
// throughput: 1 byte per cycle while the skid is free, from the combinational walk update
// a two-entry output (result register plus skid) keeps bytes flowing while a verdict waits
// reset: synchronous active-low i_rst_n clears the walk state, expected_xid and both
// output entries; no clearing pass, the block takes bytes in the first cycle after reset
`default_nettype none

module dhcp_reply_validator import drv_pkg::*; #(
    parameter int MAX_OPTION_BYTES = MAX_OPTION_BYTES_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_we,
    input  wire [XID_W-1:0]  i_cfg_wdata,
    drv_byte_if.sink         i_byte,
    drv_result_if.source     o_result
);

    // sizes that follow from the kept option area
    localparam int KEEP_LIMIT = OPT_START + MAX_OPTION_BYTES;
    localparam int POS_W      = $clog2(KEEP_LIMIT + 1);
    localparam int OFF_W      = $clog2(MAX_OPTION_BYTES + 1);
    localparam int SUM_W      = $clog2(MAX_OPTION_BYTES + 256 + 1);
    localparam int OPTB_MAX   = (1 << OPTB_W) - 1;

    // configuration
    logic [XID_W-1:0] r_xid;

    // per-payload walk state
    logic [POS_W-1:0] r_pos,      n_pos;
    logic             r_op_ok,    n_op_ok;
    logic             r_xid_ok,   n_xid_ok;
    logic             r_ck_ok,    n_ck_ok;
    logic [OFF_W-1:0] r_tag_off,  n_tag_off;
    logic             r_len_pend, n_len_pend;
    logic             r_end,      n_end;

    // output register and skid entry
    logic                 r_out_valid;
    logic [VERDICT_W-1:0] r_out_verdict;
    logic [OPTB_W-1:0]    r_out_optb;
    logic                 r_skd_valid;
    logic [VERDICT_W-1:0] r_skd_verdict;
    logic [OPTB_W-1:0]    r_skd_optb;

    logic                 in_fire;
    logic                 out_fire;
    logic                 res_load;
    logic [OFF_W-1:0]     opt_off;
    logic [SUM_W-1:0]     skip_sum;
    logic [POS_W-1:0]     opt_len;
    logic                 xid_final;
    logic [VERDICT_W-1:0] res_verdict;
    logic [OPTB_W-1:0]    res_optb;

    // a new transaction is blocked only while both output entries are full
    assign i_byte.ready = !r_skd_valid;
    assign in_fire      = i_byte.valid && i_byte.ready;
    assign out_fire     = r_out_valid && o_result.ready;
    assign res_load     = in_fire && i_byte.is_last;

    assign o_result.valid        = r_out_valid;
    assign o_result.verdict      = r_out_verdict;
    assign o_result.option_bytes = r_out_optb;

    // offset into the option area, only meaningful when pos is in it
    assign opt_off  = OFF_W'(r_pos - POS_W'(OPT_START));
    assign skip_sum = SUM_W'(opt_off) + SUM_W'(i_byte.payload_byte) + SUM_W'(1);

    // walk update for one accepted byte
    always_comb begin
        n_pos      = r_pos;
        n_op_ok    = r_op_ok;
        n_xid_ok   = r_xid_ok;
        n_ck_ok    = r_ck_ok;
        n_tag_off  = r_tag_off;
        n_len_pend = r_len_pend;
        n_end      = r_end;
        // bytes beyond the kept area are dropped, only their last mark counts
        if (in_fire && (r_pos < POS_W'(KEEP_LIMIT))) begin
            n_pos = r_pos + POS_W'(1);
            if (r_pos == POS_W'(OP_POS)) begin
                n_op_ok = (i_byte.payload_byte == OP_REPLY);
            end else if ((r_pos >= POS_W'(XID_FIRST)) && (r_pos <= POS_W'(XID_LAST))) begin
                if (i_byte.payload_byte != xid_byte(r_xid, r_pos[1:0])) begin
                    n_xid_ok = 1'b0;
                end
            end else if ((r_pos >= POS_W'(HDR_LEN)) && (r_pos < POS_W'(OPT_START))) begin
                // cookie starts on a multiple of four, low bits pick the byte
                if (i_byte.payload_byte != COOKIE[r_pos[1:0]]) begin
                    n_ck_ok = 1'b0;
                end
            end else if ((r_pos >= POS_W'(OPT_START)) && !r_end) begin
                if (r_len_pend) begin
                    // skip to the next tag, clamped to the end of the kept area
                    if (skip_sum > SUM_W'(MAX_OPTION_BYTES)) begin
                        n_tag_off = OFF_W'(MAX_OPTION_BYTES);
                    end else begin
                        n_tag_off = skip_sum[OFF_W-1:0];
                    end
                    n_len_pend = 1'b0;
                end else if (opt_off == r_tag_off) begin
                    if (i_byte.payload_byte == OPT_PAD) begin
                        n_tag_off = opt_off + OFF_W'(1);
                    end else if (i_byte.payload_byte == OPT_END) begin
                        n_end = 1'b1;
                    end else begin
                        n_len_pend = 1'b1;
                    end
                end
            end
        end
    end

    // verdict from the state after the last byte
    always_comb begin
        xid_final = n_xid_ok;
        // xid bytes that never arrived compare against zero
        for (int k = 0; k < 4; k++) begin
            if ((n_pos <= POS_W'(XID_FIRST + k)) &&
                (xid_byte(r_xid, 2'(k)) != '0)) begin
                xid_final = 1'b0;
            end
        end

        if (n_pos > POS_W'(OPT_START)) begin
            opt_len = n_pos - POS_W'(OPT_START);
        end else begin
            opt_len = '0;
        end

        if (opt_len > POS_W'(OPTB_MAX)) begin
            res_optb = OPTB_W'(OPTB_MAX);
        end else begin
            res_optb = OPTB_W'(opt_len);
        end

        if (!n_op_ok) begin
            res_verdict = VERDICT_NOT_REPLY;
        end else if (!xid_final) begin
            res_verdict = VERDICT_XID_BAD;
        end else if ((opt_len != '0) && !n_ck_ok) begin
            res_verdict = VERDICT_COOKIE;
        end else if ((opt_len != '0) && !n_end) begin
            res_verdict = VERDICT_NO_END;
        end else begin
            res_verdict = VERDICT_ACCEPT;
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xid <= '0;
        end else if (i_cfg_we) begin
            r_xid <= i_cfg_wdata;
        end
    end

    // walk state, cleared after the last byte of a payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || res_load) begin
            r_pos      <= '0;
            r_op_ok    <= 1'b0;
            r_xid_ok   <= 1'b1;
            r_ck_ok    <= 1'b1;
            r_tag_off  <= '0;
            r_len_pend <= 1'b0;
            r_end      <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_op_ok    <= n_op_ok;
            r_xid_ok   <= n_xid_ok;
            r_ck_ok    <= n_ck_ok;
            r_tag_off  <= n_tag_off;
            r_len_pend <= n_len_pend;
            r_end      <= n_end;
        end
    end

    // output entry valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (r_skd_valid) begin
            // no new result can arrive while the skid is full
            if (out_fire) begin
                r_skd_valid <= 1'b0;
            end
        end else if (res_load) begin
            if (r_out_valid && !out_fire) begin
                r_skd_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    // output entry payloads
    always_ff @(posedge i_clk) begin
        if (r_skd_valid) begin
            if (out_fire) begin
                r_out_verdict <= r_skd_verdict;
                r_out_optb    <= r_skd_optb;
            end
        end else if (res_load) begin
            if (r_out_valid && !out_fire) begin
                r_skd_verdict <= res_verdict;
                r_skd_optb    <= res_optb;
            end else begin
                r_out_verdict <= res_verdict;
                r_out_optb    <= res_optb;
            end
        end
    end

`ifndef NO_ASSERTIONS
    // the skid only fills behind a waiting result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_valid |-> r_out_valid)
        else $error("skid entry valid without output entry");

    // a last byte always leaves a verdict waiting
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_load |=> r_out_valid)
        else $error("no verdict after last byte");

    // a last byte restarts the walk
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_load |=> (r_pos == '0) && !r_end && !r_len_pend)
        else $error("walk state not cleared after last byte");

    // position and tag offset stay inside the kept area
    a_walk_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos <= POS_W'(KEEP_LIMIT)) && (r_tag_off <= OFF_W'(MAX_OPTION_BYTES)))
        else $error("walk state beyond kept area");
`endif

endmodule

`default_nettype wire
